/* src/pbrq_pkg.sv */
// ----------------------------------------------------------------------------
// pbrq_pkg
// Shared types, codes and helpers for the priority bitmap ready queue.
// ----------------------------------------------------------------------------
package pbrq_pkg;

  // command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_CHOOSE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ALREADY = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // two-level bitmap geometry: 32 priorities per group
  localparam int          LVL_SHIFT = 5;
  localparam int          LVL_SIZE  = 32;
  localparam logic [4:0]  LVL_MASK  = 5'h1f;

  // input beat
  typedef struct packed {
    logic       cmd;
    logic [5:0] thread_id;
    logic [7:0] prio;
    logic       cur_running;
    logic       cur_affine;
    logic       cur_has_budget;
  } pbrq_in_t;

  // result beat
  typedef struct packed {
    logic [5:0] chosen_id;
    logic       kept_current;
    logic [1:0] status;
  } pbrq_out_t;

  // bitmap unit control
  typedef struct packed {
    logic set;     // mark priority non-empty
    logic clr;     // mark priority empty
    logic by_grp;  // read level word by group index instead of by priority
  } bm_ctl_t;

  // bitmap unit status
  typedef struct packed {
    logic nonempty;  // some priority is non-empty
    logic hit;       // level bit of the addressed priority
  } bm_stat_t;

  // index of the highest set bit, zero when no bit is set
  function automatic logic [4:0] top_bit32(input logic [LVL_SIZE-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < LVL_SIZE; i++) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/priority_bitmap_ready_queue.sv */
// Sequence: an enqueue reads the ready flag, then appends; a choose finds the top
//   group, stops there on an empty queue, else finds the top priority and then keeps or pops, maybe re-enqueuing.
// One command at a time: in_stall holds from accept until the result
//   registers, and longer while out_stall holds a result.
// Reset: bitmap clears at once, then a pass over all NUM_THREADS entries
//   clears the ready flags before the first command is accepted.
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue
// Per-priority thread FIFOs with a two-level bitmap, enqueue and choose.
// ----------------------------------------------------------------------------
module priority_bitmap_ready_queue #(
  parameter int NUM_PRIOS   = 256,
  parameter int NUM_THREADS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbrq_pkg::pbrq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbrq_pkg::pbrq_out_t out_data
);

  localparam int PW = $clog2(NUM_PRIOS);
  localparam int TW = $clog2(NUM_THREADS);
  localparam int NG = (NUM_PRIOS + pbrq_pkg::LVL_SIZE - 1) / pbrq_pkg::LVL_SIZE;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int XW = PW + pbrq_pkg::LVL_SHIFT;
  localparam int CW = ((PW > 8) ? PW : 8) + 1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_WR,
    S_FIND_G,
    S_FIND_L,
    S_DEC,
    S_POP_RD,
    S_POP_WR,
    S_RES
  } state_t;

  // thread id folded into the thread range
  function automatic logic [TW-1:0] tid_of(input logic [5:0] x);
    logic [TW-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (x == 6'(i)) begin
        r = TW'(i % NUM_THREADS);
      end
    end
    return r;
  endfunction

  // priority saturated to the top priority
  function automatic logic [PW-1:0] clamp_prio(input logic [7:0] x);
    logic [CW-1:0] w;
    logic [PW-1:0] r;
    w = CW'(x);
    if (w >= CW'(NUM_PRIOS)) begin
      r = PW'(NUM_PRIOS - 1);
    end else begin
      r = PW'(w);
    end
    return r;
  endfunction

  // thread index to the 6-bit result field
  function automatic logic [5:0] id6(input logic [TW-1:0] t);
    logic [TW+5:0] e;
    e = (TW + 6)'(t);
    return e[5:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [TW-1:0]       cnt_r, cnt_nxt;
  logic                cmd_r, cmd_nxt;
  logic [TW-1:0]       tid_r, tid_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic                running_r, running_nxt;
  logic                runnable_r, runnable_nxt;
  logic                budget_r, budget_nxt;
  logic [GW-1:0]       g_r, g_nxt;
  logic [PW-1:0]       hp_r, hp_nxt;
  logic [TW-1:0]       h_r, h_nxt;
  logic                last_r, last_nxt;
  pbrq_pkg::pbrq_out_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  pbrq_pkg::pbrq_out_t out_r, out_nxt;

  // bitmap unit
  pbrq_pkg::bm_ctl_t   bm_ctl;
  pbrq_pkg::bm_stat_t  bm_stat;
  logic [PW-1:0]       bm_prio;
  logic [GW-1:0]       bm_top_grp;
  logic [4:0]          bm_top_lvl;

  // memory ports
  logic                rdy_we, rdy_wdata, rdy_rdata;
  logic [TW-1:0]       rdy_waddr;
  logic                head_we;
  logic [PW-1:0]       head_waddr;
  logic [TW-1:0]       head_wdata, head_rdata;
  logic                tail_we;
  logic [PW-1:0]       tail_raddr;
  logic [TW-1:0]       tail_rdata;
  logic                link_we;
  logic [TW-1:0]       link_rdata;

  logic                keep;

  pbrq_bmap #(
    .NUM_PRIOS (NUM_PRIOS)
  ) u_bmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bm_ctl),
    .prio    (bm_prio),
    .grp     (g_r),
    .stat    (bm_stat),
    .top_grp (bm_top_grp),
    .top_lvl (bm_top_lvl)
  );

  pbrq_ram #(.DEPTH(NUM_THREADS), .WIDTH(1)) u_ready (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (rdy_waddr),
    .wdata (rdy_wdata),
    .raddr (tid_r),
    .rdata (rdy_rdata)
  );

  pbrq_ram #(.DEPTH(NUM_PRIOS), .WIDTH(TW)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (hp_r),
    .rdata (head_rdata)
  );

  pbrq_ram #(.DEPTH(NUM_PRIOS), .WIDTH(TW)) u_tail (
    .clk   (clk),
    .we    (tail_we),
    .waddr (p_r),
    .wdata (tid_r),
    .raddr (tail_raddr),
    .rdata (tail_rdata)
  );

  pbrq_ram #(.DEPTH(NUM_THREADS), .WIDTH(TW)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (tail_rdata),
    .wdata (tid_r),
    .raddr (head_rdata),
    .rdata (link_rdata)
  );

  // runnable current thread wins over a lower queued priority, or an equal one with budget
  assign keep = runnable_r && ((p_r > hp_r) || ((p_r == hp_r) && budget_r));

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory and bitmap control
  always_comb begin
    rdy_we     = 1'b0;
    rdy_waddr  = tid_r;
    rdy_wdata  = 1'b0;
    head_we    = 1'b0;
    head_waddr = p_r;
    head_wdata = tid_r;
    tail_we    = 1'b0;
    tail_raddr = (state_r == S_DEC) ? hp_r : p_r;
    link_we    = 1'b0;
    bm_ctl     = '0;
    bm_prio    = p_r;
    case (state_r)
      S_CLR: begin
        rdy_we    = 1'b1;
        rdy_waddr = cnt_r;
      end
      S_FIND_L: begin
        bm_ctl.by_grp = 1'b1;
      end
      S_ENQ_WR: begin
        if (!rdy_rdata) begin
          rdy_we     = 1'b1;
          rdy_wdata  = 1'b1;
          tail_we    = 1'b1;
          bm_ctl.set = 1'b1;
          if (bm_stat.hit) begin
            link_we = 1'b1;
          end else begin
            head_we = 1'b1;
          end
        end
      end
      S_POP_RD: begin
        rdy_we     = 1'b1;
        rdy_waddr  = head_rdata;
        bm_prio    = hp_r;
        bm_ctl.clr = (head_rdata == tail_rdata);
      end
      S_POP_WR: begin
        head_we    = !last_r;
        head_waddr = hp_r;
        head_wdata = link_rdata;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    tid_nxt       = tid_r;
    p_nxt         = p_r;
    running_nxt   = running_r;
    runnable_nxt  = runnable_r;
    budget_nxt    = budget_r;
    g_nxt         = g_r;
    hp_nxt        = hp_r;
    h_nxt         = h_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      // clear ready flags one entry a cycle
      S_CLR: begin
        cnt_nxt = cnt_r + TW'(1);
        if (cnt_r == TW'(NUM_THREADS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      // capture the input beat
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data.cmd;
          tid_nxt      = tid_of(in_data.thread_id);
          p_nxt        = clamp_prio(in_data.prio);
          running_nxt  = in_data.cur_running;
          runnable_nxt = in_data.cur_running && in_data.cur_affine;
          budget_nxt   = in_data.cur_has_budget;
          res_nxt      = '{chosen_id: '0, kept_current: 1'b0, status: pbrq_pkg::ST_OK};
          state_nxt    = (in_data.cmd == pbrq_pkg::CMD_ENQUEUE) ? S_ENQ_RD : S_FIND_G;
        end
      end
      S_ENQ_RD: begin
        state_nxt = S_ENQ_WR;
      end
      // append at tail unless already ready; a re-enqueue keeps the popped result
      S_ENQ_WR: begin
        if (cmd_r == pbrq_pkg::CMD_ENQUEUE && rdy_rdata) begin
          res_nxt.status = pbrq_pkg::ST_ALREADY;
        end
        state_nxt = S_RES;
      end
      // top group, or nothing queued
      S_FIND_G: begin
        if (!bm_stat.nonempty) begin
          if (runnable_r) begin
            res_nxt = '{chosen_id: id6(tid_r), kept_current: 1'b1,
                        status: pbrq_pkg::ST_OK};
          end else begin
            res_nxt.status = pbrq_pkg::ST_NONE;
          end
          state_nxt = S_RES;
        end else begin
          g_nxt     = bm_top_grp;
          state_nxt = S_FIND_L;
        end
      end
      // top priority within the group
      S_FIND_L: begin
        hp_nxt    = PW'((XW'(g_r) << pbrq_pkg::LVL_SHIFT) | XW'(bm_top_lvl));
        state_nxt = S_DEC;
      end
      // keep current thread or pop the head
      S_DEC: begin
        if (keep) begin
          res_nxt   = '{chosen_id: id6(tid_r), kept_current: 1'b1,
                        status: pbrq_pkg::ST_OK};
          state_nxt = S_RES;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        h_nxt     = head_rdata;
        last_nxt  = (head_rdata == tail_rdata);
        state_nxt = S_POP_WR;
      end
      // advance head, then re-enqueue a still running current thread that was not popped
      S_POP_WR: begin
        res_nxt = '{chosen_id: id6(h_r), kept_current: 1'b0, status: pbrq_pkg::ST_OK};
        if (running_r && (h_r != tid_r)) begin
          state_nxt = S_ENQ_RD;
        end else begin
          state_nxt = S_RES;
        end
      end
      // hand the result to the output register
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    tid_r      <= tid_nxt;
    p_r        <= p_nxt;
    running_r  <= running_nxt;
    runnable_r <= runnable_nxt;
    budget_r   <= budget_nxt;
    g_r        <= g_nxt;
    hp_r       <= hp_nxt;
    h_r        <= h_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

/* src/pbrq_ram.sv */
// ----------------------------------------------------------------------------
// pbrq_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbrq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/pbrq_bmap.sv */
// ----------------------------------------------------------------------------
// pbrq_bmap
// Two-level bitmap of non-empty priorities with highest-bit search.
// ----------------------------------------------------------------------------
module pbrq_bmap #(
  parameter int NUM_PRIOS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pbrq_pkg::bm_ctl_t                      ctl,
  input  logic [$clog2(NUM_PRIOS)-1:0]           prio,
  input  logic [((NUM_PRIOS + 31) / 32 > 1 ?
                 $clog2((NUM_PRIOS + 31) / 32) : 1)-1:0] grp,
  output pbrq_pkg::bm_stat_t                     stat,
  output logic [((NUM_PRIOS + 31) / 32 > 1 ?
                 $clog2((NUM_PRIOS + 31) / 32) : 1)-1:0] top_grp,
  output logic [4:0]                             top_lvl
);

  localparam int PW = $clog2(NUM_PRIOS);
  localparam int NG = (NUM_PRIOS + pbrq_pkg::LVL_SIZE - 1) / pbrq_pkg::LVL_SIZE;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int XW = PW + pbrq_pkg::LVL_SHIFT;

  logic [NG-1:0]                    grp_r;
  logic [NG-1:0]                    grp_nxt;
  logic [pbrq_pkg::LVL_SIZE-1:0]    lvl_r   [NG];
  logic [pbrq_pkg::LVL_SIZE-1:0]    lvl_nxt [NG];

  logic [XW-1:0]                    prio_x;
  logic [GW-1:0]                    prio_grp;
  logic [4:0]                       prio_bit;
  logic [GW-1:0]                    addr;
  logic [pbrq_pkg::LVL_SIZE-1:0]    word;
  logic [pbrq_pkg::LVL_SIZE-1:0]    word_clr;

  // split priority into group index and bit within the group
  assign prio_x   = XW'(prio);
  assign prio_grp = GW'(prio_x >> pbrq_pkg::LVL_SHIFT);
  assign prio_bit = prio_x[4:0] & pbrq_pkg::LVL_MASK;

  // single read port on the level words
  assign addr     = ctl.by_grp ? grp : prio_grp;
  assign word     = lvl_r[addr];
  assign word_clr = word & ~(pbrq_pkg::LVL_SIZE'(1) << prio_bit);

  // status and highest-bit search
  assign stat.nonempty = |grp_r;
  assign stat.hit      = word[prio_bit];
  assign top_grp       = GW'(pbrq_pkg::top_bit32(pbrq_pkg::LVL_SIZE'(grp_r)));
  assign top_lvl       = pbrq_pkg::top_bit32(word);

  // set or clear one priority
  always_comb begin
    grp_nxt = grp_r;
    lvl_nxt = lvl_r;
    if (ctl.set) begin
      lvl_nxt[addr]     = word | (pbrq_pkg::LVL_SIZE'(1) << prio_bit);
      grp_nxt[prio_grp] = 1'b1;
    end else if (ctl.clr) begin
      lvl_nxt[addr] = word_clr;
      if (word_clr == '0) begin
        grp_nxt[prio_grp] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
      for (int i = 0; i < NG; i++) begin
        lvl_r[i] <= '0;
      end
    end else begin
      grp_r <= grp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority bitmap ready queue. A directed table
// covers the empty queue, duplicate enqueues and each keep/pop/re-enqueue path.
// Mostly well-formed random scheduling traffic follows. Every accepted beat is
// run through an in-bench scheduler model and each result beat is compared in
// order, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_PRIOS   = 256;
  localparam int          NUM_THREADS = 64;
  localparam int          NUM_GROUPS  = NUM_PRIOS / pbrq_pkg::LVL_SIZE;
  localparam int          RAND_BEATS  = 930;
  localparam int          LONG_HOLD   = 250;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pbrq_pkg::pbrq_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  pbrq_pkg::pbrq_out_t out_data;

  // directed stimulus row, with an optional hand-written result
  typedef struct packed {
    pbrq_pkg::pbrq_in_t  beat;
    logic                typed;
    pbrq_pkg::pbrq_out_t want;
  } stim_row_t;

  // scheduler model state
  logic [NUM_GROUPS-1:0]         grp_map;
  logic [pbrq_pkg::LVL_SIZE-1:0] lvl_map   [NUM_GROUPS];
  logic [5:0]                    fifo_head [NUM_PRIOS];
  logic [5:0]                    fifo_tail [NUM_PRIOS];
  logic [5:0]                    link_tab  [NUM_THREADS];
  logic                          is_ready  [NUM_THREADS];

  // stimulus bookkeeping
  stim_row_t            dir_rows [$];
  pbrq_pkg::pbrq_out_t  owed_results [$];
  logic [7:0]           thr_prio [NUM_THREADS];
  logic [5:0]           last_pick;
  logic                 gaps_on;
  logic                 hold_off_req;
  logic                 quiet_tail;
  int                   err_cnt;
  int                   n_enq, n_already, n_choose, n_keep, n_pop, n_none;
  int unsigned          cyc_cnt = 0;

  priority_bitmap_ready_queue #(
    .NUM_PRIOS  (NUM_PRIOS),
    .NUM_THREADS(NUM_THREADS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results owed", $time, cyc_cnt,
               owed_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // highest set bit, zero when empty
  function automatic int msb_index(input logic [31:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        r = i;
      end
    end
    return r;
  endfunction

  // append a thread to its priority fifo, false if it is already ready
  function automatic bit mark_ready(input logic [5:0] tid, input logic [7:0] p);
    int g;
    g = p >> pbrq_pkg::LVL_SHIFT;
    if (is_ready[tid]) begin
      return 1'b0;
    end
    is_ready[tid] = 1'b1;
    if (lvl_map[g][p[4:0]]) begin
      link_tab[fifo_tail[p]] = tid;
    end else begin
      fifo_head[p] = tid;
    end
    fifo_tail[p]       = tid;
    lvl_map[g][p[4:0]] = 1'b1;
    grp_map[g]         = 1'b1;
    return 1'b1;
  endfunction

  // remove the head of a priority fifo, clearing bitmap bits when it empties
  function automatic logic [5:0] take_head(input logic [7:0] p);
    int         g;
    logic [5:0] h;
    g = p >> pbrq_pkg::LVL_SHIFT;
    h = fifo_head[p];
    is_ready[h] = 1'b0;
    if (fifo_head[p] == fifo_tail[p]) begin
      lvl_map[g][p[4:0]] = 1'b0;
      if (lvl_map[g] == '0) begin
        grp_map[g] = 1'b0;
      end
    end else begin
      fifo_head[p] = link_tab[h];
    end
    return h;
  endfunction

  // expected result of one command, updating the model state
  function automatic pbrq_pkg::pbrq_out_t predict_sched(input pbrq_pkg::pbrq_in_t b);
    pbrq_pkg::pbrq_out_t r;
    logic                runnable;
    logic [7:0]          hp;
    logic [5:0]          h;
    int                  g;
    r              = '0;
    r.status       = pbrq_pkg::ST_OK;
    runnable       = b.cur_running && b.cur_affine;
    if (b.cmd == pbrq_pkg::CMD_ENQUEUE) begin
      if (!mark_ready(b.thread_id, b.prio)) begin
        r.status = pbrq_pkg::ST_ALREADY;
      end
      return r;
    end
    // empty queue: keep current if it can run at all
    if (grp_map == '0) begin
      if (runnable) begin
        r.chosen_id    = b.thread_id;
        r.kept_current = 1'b1;
      end else begin
        r.status = pbrq_pkg::ST_NONE;
      end
      return r;
    end
    g  = msb_index(32'(grp_map));
    hp = 8'((g << pbrq_pkg::LVL_SHIFT) + msb_index(lvl_map[g]));
    // budget only breaks ties at equal priority
    if (runnable && (b.prio > hp || (b.prio == hp && b.cur_has_budget))) begin
      r.chosen_id    = b.thread_id;
      r.kept_current = 1'b1;
      return r;
    end
    h = take_head(hp);
    if (b.cur_running && h != b.thread_id) begin
      void'(mark_ready(b.thread_id, b.prio));
    end
    r.chosen_id = h;
    return r;
  endfunction

  function automatic void add_row(input logic c, input logic [5:0] t, input logic [7:0] p,
                                  input logic run, input logic aff, input logic bud,
                                  input logic typed, input logic [5:0] wid,
                                  input logic wkeep, input logic [1:0] wst);
    stim_row_t row;
    row.beat  = '{cmd: c, thread_id: t, prio: p, cur_running: run, cur_affine: aff,
                  cur_has_budget: bud};
    row.typed = typed;
    row.want  = '{chosen_id: wid, kept_current: wkeep, status: wst};
    dir_rows.push_back(row);
  endfunction

  // priorities cluster on a few values so fifos grow deep
  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd31;
      3: return 8'd32;
      4: return 8'd224;
      5: return 8'd100;
      6: return 8'd7;
      7: return 8'd223;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly scheduler-like traffic, some fully random noise
  function automatic pbrq_pkg::pbrq_in_t next_random_beat();
    pbrq_pkg::pbrq_in_t b;
    int                 nr;
    int                 tries;
    nr = 0;
    foreach (is_ready[i]) begin
      nr += is_ready[i];
    end
    b.cmd            = ($urandom_range(0, 99) < (nr > 40 ? 20 : 55)) ?
                       pbrq_pkg::CMD_ENQUEUE : pbrq_pkg::CMD_CHOOSE;
    b.thread_id      = 6'($urandom);
    b.prio           = 8'($urandom);
    b.cur_running    = 1'($urandom);
    b.cur_affine     = 1'($urandom);
    b.cur_has_budget = 1'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      return b;
    end
    if (b.cmd == pbrq_pkg::CMD_ENQUEUE) begin
      tries = 0;
      while (is_ready[b.thread_id] && tries < 8) begin
        b.thread_id = 6'($urandom);
        tries++;
      end
      if ($urandom_range(0, 9) == 0) begin
        thr_prio[b.thread_id] = pick_prio();
      end
      b.prio = thr_prio[b.thread_id];
    end else begin
      b.thread_id   = last_pick;
      b.prio        = thr_prio[last_pick];
      b.cur_running = ($urandom_range(0, 4) != 0);
      b.cur_affine  = ($urandom_range(0, 7) != 0);
    end
    return b;
  endfunction

  // offer one beat, predict on accept, then maybe idle
  task automatic send_beat(input pbrq_pkg::pbrq_in_t b, input logic typed,
                           input pbrq_pkg::pbrq_out_t want);
    pbrq_pkg::pbrq_out_t guess;
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    guess = predict_sched(b);
    owed_results.push_back(typed ? want : guess);
    if (b.cmd == pbrq_pkg::CMD_ENQUEUE) begin
      n_enq++;
      n_already += (guess.status == pbrq_pkg::ST_ALREADY);
    end else begin
      n_choose++;
      n_none += (guess.status == pbrq_pkg::ST_NONE);
      n_keep += guess.kept_current;
      n_pop  += (guess.status == pbrq_pkg::ST_OK && !guess.kept_current);
      if (guess.status == pbrq_pkg::ST_OK) begin
        last_pick = guess.chosen_id;
      end
    end
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every owed result is back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (owed_results.size() != 0);
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pbrq_pkg::pbrq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual id=%0d kept=%0d st=%0d",
                 $time, out_data.chosen_id, out_data.kept_current, out_data.status);
        err_cnt++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.chosen_id !== want.chosen_id
            || out_data.kept_current !== want.kept_current
            || out_data.status !== want.status) begin
          $display({"%0t: result mismatch, expected id=%0d kept=%0d st=%0d,",
                    " actual id=%0d kept=%0d st=%0d"},
                   $time, want.chosen_id, want.kept_current, want.status,
                   out_data.chosen_id, out_data.kept_current, out_data.status);
          err_cnt++;
        end
      end
    end
  end

  // receiver side: random stall bursts, one long hold-off, quiet at the end
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_off_req);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // sender side and run control
  initial begin
    pbrq_pkg::pbrq_in_t b;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    quiet_tail   = 1'b0;
    err_cnt      = 0;
    n_enq = 0; n_already = 0; n_choose = 0; n_keep = 0; n_pop = 0; n_none = 0;
    last_pick    = '0;
    grp_map      = '0;
    foreach (lvl_map[i]) lvl_map[i] = '0;
    foreach (is_ready[i]) is_ready[i] = 1'b0;
    foreach (thr_prio[i]) thr_prio[i] = pick_prio();

    // empty queue: keep runnable current, else nothing runnable
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd12, 8'd40,  1'b1, 1'b1, 1'b0, 1'b1, 6'd12, 1'b1,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd12, 8'd40,  1'b1, 1'b0, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_NONE);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd12, 8'd40,  1'b0, 1'b1, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_NONE);
    // enqueues at the extremes, one duplicate
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd63, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd63, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_ALREADY);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd0,  8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd1,  8'd255, 1'b1, 1'b0, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd2,  8'd31,  1'b0, 1'b1, 1'b0, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd3,  8'd32,  1'b0, 1'b0, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_ENQUEUE, 6'd4,  8'd224, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // equal priority with budget keeps, without budget pops and requeues
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd10, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd10, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // popped thread is the current one: no requeue
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd1,  8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // not running: pop only
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd20, 8'd100, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // higher priority current wins
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd21, 8'd230, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // running but not affine
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd4,  8'd224, 1'b1, 1'b0, 1'b1, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // requeue of a thread that is already ready is dropped
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd2,  8'd31,  1'b1, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd30, 8'd5,   1'b1, 1'b1, 1'b1, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd31, 8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    // drain the last fifo
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd40, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd40, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 6'd0,  1'b0,
            pbrq_pkg::ST_OK);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd40, 8'd0,   1'b0, 1'b1, 1'b1, 1'b1, 6'd0,  1'b0,
            pbrq_pkg::ST_NONE);
    add_row(pbrq_pkg::CMD_CHOOSE,  6'd63, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 6'd63, 1'b1,
            pbrq_pkg::ST_OK);

    // synchronous reset, then the block runs its clearing pass
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_until_drained();

    // random scheduling traffic
    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i == 300) begin
        hold_off_req <= 1'b1;
      end
      if (i == 360) begin
        hold_off_req <= 1'b0;
      end
      // sender pause until every owed result is back
      if (i == 600) begin
        wait_until_drained();
      end
      if (i == RAND_BEATS - 120) begin
        gaps_on    = 1'b0;
        quiet_tail <= 1'b1;
      end
      b = next_random_beat();
      send_beat(b, 1'b0, '0);
    end

    wait_until_drained();
    repeat (16) @(posedge clk);
    $display("tb: %0d enqueues (%0d already ready), %0d chooses (%0d kept, %0d popped, %0d none)",
             n_enq, n_already, n_choose, n_keep, n_pop, n_none);
    $display("tb: stall bursts on both channels, one %0d-cycle output hold-off, one drain pause",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/pbrq_pkg.sv
src/pbrq_ram.sv
src/pbrq_bmap.sv
src/priority_bitmap_ready_queue.sv
verif/tb.sv
